[sv/btg_pkg.sv]
package btg_pkg;

  // Counter width of the table; the result carries its low OutCountBits bits.
  localparam int unsigned CounterBits  = 16;
  localparam int unsigned OutCountBits = 16;
  localparam int unsigned ByteBits     = 8;
  localparam int unsigned IndexBits    = 3 * ByteBits;
  localparam int unsigned TableDepth   = 256 * 256 * 256;

  localparam logic ReqData  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef logic [CounterBits-1:0] count_t;
  typedef logic [IndexBits-1:0]   index_t;

  localparam count_t CounterMax = '1;

  typedef struct packed {
    logic                req_type;
    logic [ByteBits-1:0] data_byte;
    logic                stream_start;
    index_t              query_index;
  } in_t;

  typedef struct packed {
    logic [OutCountBits-1:0] count_value;
    logic                    trigram_formed;
    logic                    saturated;
  } out_t;

  // Table access prepared by the history front end.
  typedef struct packed {
    logic   query;
    logic   formed;
    index_t addr;
  } lookup_t;

  // Table write port.
  typedef struct packed {
    logic   en;
    index_t addr;
    count_t data;
  } wr_t;

  typedef enum logic {
    PhaseClear,
    PhaseRun
  } phase_e;

  // Low OutCountBits bits of a counter, zero-extended when the counter is narrower.
  function automatic logic [OutCountBits-1:0] to_out(input count_t val);
    logic [CounterBits+OutCountBits-1:0] ext;
    ext = {{OutCountBits{1'b0}}, val};
    return ext[OutCountBits-1:0];
  endfunction

endpackage

[sv/btg_ram.sv]
module btg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/btg_hist.sv]
module btg_hist (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  btg_pkg::in_t     item_i,
  output btg_pkg::lookup_t lookup_o
);
  import btg_pkg::*;

  logic [ByteBits-1:0] older_q, older_d;
  logic [ByteBits-1:0] newer_q, newer_d;
  logic [1:0]          fill_q, fill_d;
  logic [1:0]          fill_eff;

  always_comb begin
    fill_eff = item_i.stream_start ? 2'd0 : fill_q;
    older_d  = older_q;
    newer_d  = newer_q;
    fill_d   = fill_q;

    lookup_o.query  = (item_i.req_type == ReqQuery);
    lookup_o.formed = 1'b0;
    lookup_o.addr   = item_i.query_index;

    if (item_i.req_type == ReqData) begin
      lookup_o.formed = (fill_eff == 2'd2);
      lookup_o.addr   = {older_q, newer_q, item_i.data_byte};
      if (accept_i) begin
        older_d = newer_q;
        newer_d = item_i.data_byte;
        fill_d  = (fill_eff == 2'd2) ? 2'd2 : fill_eff + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      newer_q <= '0;
      fill_q  <= '0;
    end else begin
      older_q <= older_d;
      newer_q <= newer_d;
      fill_q  <= fill_d;
    end
  end

endmodule

[sv/btg_rmw.sv]
module btg_rmw (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             issue_i,
  input  btg_pkg::lookup_t lookup_i,
  input  btg_pkg::count_t  rdata_i,
  output logic             stage_free_o,
  output btg_pkg::wr_t     wr_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output btg_pkg::out_t    out_data_o
);
  import btg_pkg::*;

  logic    s1_valid_q, s1_valid_d;
  lookup_t s1_q;
  logic    fwd_q;
  count_t  fwd_data_q;
  logic    out_valid_q, out_valid_d;
  out_t    out_q;

  logic    advance;
  count_t  cur;
  count_t  incr;
  out_t    res;

  always_comb begin
    advance      = s1_valid_q && (!out_valid_q || out_ready_i);
    stage_free_o = !s1_valid_q || advance;

    // Take the value just written when the read raced that write.
    cur  = fwd_q ? fwd_data_q : rdata_i;
    incr = (cur == CounterMax) ? cur : cur + count_t'(1);

    wr_o.en   = advance && s1_q.formed;
    wr_o.addr = s1_q.addr;
    wr_o.data = incr;

    res = '0;
    if (s1_q.formed) begin
      res.count_value    = to_out(incr);
      res.trigram_formed = 1'b1;
      res.saturated      = (incr == CounterMax);
    end else if (s1_q.query) begin
      res.count_value = to_out(cur);
      res.saturated   = (cur == CounterMax);
    end

    s1_valid_d = issue_i ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      s1_q       <= lookup_i;
      fwd_q      <= wr_o.en && (wr_o.addr == lookup_i.addr);
      fwd_data_q <= wr_o.data;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/byte_trigram_histogram_core.sv]
// Saturating byte-trigram histogram. Data transactions feed a byte stream; once two
// history bytes are held, each byte completes a trigram whose 16-bit counter is
// incremented (holding at its maximum) and returned. A stream_start byte drops the
// history first. Query transactions return one stored counter and change nothing.
// After reset the block sweeps the 2^24-entry counter table to zero, one entry per
// cycle, with in_ready_o low meanwhile. Then an accepted item reads the table;
// its result and write-back follow as the read stage advances. Reads and write-backs
// overlap, so while results are taken the block sustains one transaction per cycle,
// limited by the single read port and single write port of the table.
module byte_trigram_histogram_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  btg_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output btg_pkg::out_t out_data_o
);
  import btg_pkg::*;

  phase_e  phase_q, phase_d;
  index_t  clr_q, clr_d;

  logic    accept;
  logic    stage_free;
  lookup_t lookup;
  wr_t     rmw_wr;
  count_t  rdata;

  logic    ram_we;
  index_t  ram_waddr;
  count_t  ram_wdata;

  // Clear sweep, then normal operation.
  always_comb begin
    phase_d = phase_q;
    clr_d   = clr_q;
    case (phase_q)
      PhaseClear: begin
        clr_d = clr_q + index_t'(1);
        if (clr_q == '1) begin
          phase_d = PhaseRun;
        end
      end
      PhaseRun: begin
        clr_d = clr_q;
      end
      default: begin
        phase_d = PhaseClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseClear;
      clr_q   <= '0;
    end else begin
      phase_q <= phase_d;
      clr_q   <= clr_d;
    end
  end

  // After the clear sweep, accept whenever the read stage is empty or draining this cycle.
  assign in_ready_o = (phase_q == PhaseRun) && stage_free;
  assign accept     = in_valid_i && in_ready_o;

  btg_hist u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .lookup_o (lookup)
  );

  // Write port: zeros during the sweep, write-backs afterwards.
  always_comb begin
    if (phase_q == PhaseClear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = rmw_wr.en;
      ram_waddr = rmw_wr.addr;
      ram_wdata = rmw_wr.data;
    end
  end

  btg_ram #(
    .Width (CounterBits),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (lookup.addr),
    .rdata_o (rdata)
  );

  btg_rmw u_rmw (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (accept),
    .lookup_i     (lookup),
    .rdata_i      (rdata),
    .stage_free_o (stage_free),
    .wr_o         (rmw_wr),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

[dv/byte_trigram_histogram_core_tb.sv]
module byte_trigram_histogram_core_tb;
  import btg_pkg::*;

  // Clocking and run shape.
  localparam int unsigned NumDirected = 23;
  localparam int unsigned RandomItems = 1950;
  // Enough bytes of one symbol to drive its trigram counter past the top.
  localparam int unsigned SatRunBytes = 65540;
  localparam logic [ByteBits-1:0] SatByte = 8'h5A;
  localparam int unsigned DrainLimit = 100000;
  localparam int unsigned TailCycles = 16;
  localparam int unsigned SeenDepth = 64;

  // Receiver back-pressure styles, each held for a random stretch.
  typedef enum int {
    RdyAlways,
    RdyMostly,
    RdyPeriodic,
    RdySparse
  } ready_mode_e;

  // One row of the directed stimulus; want is used only where fixed is set.
  typedef struct packed {
    logic                req;
    logic [ByteBits-1:0] data;
    logic                start;
    index_t              qidx;
    logic                fixed;
    out_t                want;
  } dir_row_t;

  // Expectation attached to each transaction at send time.
  typedef struct packed {
    logic fixed;
    out_t want;
  } typed_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Histogram predictor state: two-byte history and sparse counter table.
  logic [ByteBits-1:0] hist_older;
  logic [ByteBits-1:0] hist_newer;
  logic [1:0] hist_fill;
  count_t trigram_count[index_t];
  index_t seen_idx[$];

  typed_exp_t typed_exp_q[$];
  out_t pending_counts[$];
  dir_row_t dir_rows[NumDirected];

  int unsigned errors = 0;
  int unsigned burst_left = 0;
  int unsigned n_data = 0;
  int unsigned n_query = 0;
  int unsigned n_formed = 0;
  int unsigned n_sat = 0;

  byte_trigram_histogram_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Advance the predictor by one accepted transaction and return its result.
  task automatic predict_histogram(input in_t txn, output out_t res);
    index_t idx;
    count_t cnt;
    res = '0;
    if (txn.req_type == ReqQuery) begin
      cnt = trigram_count.exists(txn.query_index) ? trigram_count[txn.query_index] : '0;
      res.count_value = OutCountBits'(cnt);
      res.saturated = (cnt == CounterMax);
      n_query++;
      return;
    end
    n_data++;
    // A stream start drops the history before the byte is taken in.
    if (txn.stream_start) hist_fill = 2'd0;
    if (hist_fill == 2'd2) begin
      idx = {hist_older, hist_newer, txn.data_byte};
      cnt = trigram_count.exists(idx) ? trigram_count[idx] : '0;
      if (cnt != CounterMax) cnt = cnt + 1'b1;
      trigram_count[idx] = cnt;
      res.count_value = OutCountBits'(cnt);
      res.trigram_formed = 1'b1;
      res.saturated = (cnt == CounterMax);
      seen_idx.push_back(idx);
      if (seen_idx.size() > SeenDepth) void'(seen_idx.pop_front());
    end
    hist_older = hist_newer;
    hist_newer = txn.data_byte;
    if (hist_fill != 2'd2) hist_fill = hist_fill + 2'd1;
  endtask

  // Compare one returned result against the oldest pending expectation.
  task automatic compare_count(input out_t got);
    out_t want;
    if (pending_counts.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual count %0d formed %0b sat %0b",
               $time, got.count_value, got.trigram_formed, got.saturated);
      errors++;
      return;
    end
    want = pending_counts.pop_front();
    if (got.count_value !== want.count_value) begin
      $display("%0t: count_value mismatch: expected %0d, actual %0d",
               $time, want.count_value, got.count_value);
      errors++;
    end
    if (got.trigram_formed !== want.trigram_formed) begin
      $display("%0t: trigram_formed mismatch: expected %0b, actual %0b",
               $time, want.trigram_formed, got.trigram_formed);
      errors++;
    end
    if (got.saturated !== want.saturated) begin
      $display("%0t: saturated mismatch: expected %0b, actual %0b",
               $time, want.saturated, got.saturated);
      errors++;
    end
    if (got.trigram_formed === 1'b1) n_formed++;
    if (got.saturated === 1'b1) n_sat++;
  endtask

  // Monitor both channels on the pre-edge values. Check the result side first;
  // a transaction accepted at this edge cannot have its result out yet.
  always @(posedge clk_i) begin : monitor
    typed_exp_t tag;
    out_t model_res;
    if (rst_ni) begin
      if (out_valid && out_ready) compare_count(out_data);
      if (in_valid && in_ready) begin
        tag = typed_exp_q.pop_front();
        predict_histogram(in_data, model_res);
        pending_counts.push_back(tag.fixed ? tag.want : model_res);
      end
    end
  end

  // Receiver: hold out_ready in one of several styles for a random stretch,
  // including stretches with no stall at all.
  always @(posedge clk_i) begin : receiver
    static ready_mode_e rdy_mode = RdyAlways;
    static int unsigned rdy_left = 0;
    static int unsigned rdy_phase = 0;
    if (rdy_left == 0) begin
      rdy_mode = ready_mode_e'($urandom_range(0, 3));
      rdy_left = $urandom_range(50, 400);
    end else begin
      rdy_left--;
    end
    rdy_phase++;
    case (rdy_mode)
      RdyAlways: begin
        out_ready <= 1'b1;
      end
      RdyMostly: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      RdyPeriodic: begin
        out_ready <= ((rdy_phase % 5) < 2);
      end
      default: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // Sender: drive one transaction and hold it until accepted. Transactions go
  // out in bursts; between bursts valid is often dropped for a random gap.
  task automatic send_txn(input in_t txn, input logic fixed, input out_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // Now and then run a long burst with no gaps.
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    typed_exp_q.push_back(typed_exp_t'{fixed, want});
    in_valid <= 1'b1;
    in_data <= txn;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Random query target: mostly a trigram seen lately, else any index.
  function automatic index_t pick_query();
    if (seen_idx.size() != 0 && $urandom_range(0, 2) != 0)
      return seen_idx[$urandom_range(0, seen_idx.size() - 1)];
    return index_t'($urandom);
  endfunction

  initial begin : stimulus
    in_t txn;
    logic [ByteBits-1:0] sym[4];
    logic [ByteBits-1:0] pool[4];
    int unsigned n_rand;
    int unsigned seg_len;
    int unsigned drain;

    hist_older = '0;
    hist_newer = '0;
    hist_fill = 2'd0;

    // Directed rows: extremes of every field, both request kinds, ignored
    // fields, history refill after a stream start, queries that leave the
    // history alone. Rows with fixed clear are checked by the predictor.
    dir_rows = '{
      '{ReqQuery, 8'h00, 1'b0, 24'h000000, 1'b1, '{16'd0, 1'b0, 1'b0}},
      '{ReqQuery, 8'hFF, 1'b1, 24'hFFFFFF, 1'b1, '{16'd0, 1'b0, 1'b0}},
      '{ReqData,  8'h00, 1'b1, 24'hFFFFFF, 1'b1, '{16'd0, 1'b0, 1'b0}},
      '{ReqData,  8'hFF, 1'b0, 24'h000000, 1'b1, '{16'd0, 1'b0, 1'b0}},
      '{ReqData,  8'h00, 1'b0, 24'hFFFFFF, 1'b1, '{16'd1, 1'b1, 1'b0}},
      '{ReqData,  8'hFF, 1'b0, 24'h000000, 1'b1, '{16'd1, 1'b1, 1'b0}},
      '{ReqData,  8'h00, 1'b0, 24'h123456, 1'b1, '{16'd2, 1'b1, 1'b0}},
      '{ReqQuery, 8'hAB, 1'b1, 24'h00FF00, 1'b1, '{16'd2, 1'b0, 1'b0}},
      '{ReqData,  8'hFF, 1'b0, 24'h000000, 1'b1, '{16'd2, 1'b1, 1'b0}},
      '{ReqData,  8'h55, 1'b1, 24'h000000, 1'b1, '{16'd0, 1'b0, 1'b0}},
      '{ReqData,  8'hAA, 1'b0, 24'h000000, 1'b1, '{16'd0, 1'b0, 1'b0}},
      '{ReqData,  8'h55, 1'b0, 24'h000000, 1'b1, '{16'd1, 1'b1, 1'b0}},
      '{ReqData,  8'h80, 1'b1, 24'h000000, 1'b1, '{16'd0, 1'b0, 1'b0}},
      '{ReqData,  8'h01, 1'b1, 24'h000000, 1'b1, '{16'd0, 1'b0, 1'b0}},
      '{ReqData,  8'h02, 1'b0, 24'h000000, 1'b1, '{16'd0, 1'b0, 1'b0}},
      '{ReqData,  8'h03, 1'b0, 24'h000000, 1'b1, '{16'd1, 1'b1, 1'b0}},
      '{ReqQuery, 8'h00, 1'b0, 24'h010203, 1'b1, '{16'd1, 1'b0, 1'b0}},
      '{ReqQuery, 8'h00, 1'b0, 24'h800102, 1'b1, '{16'd0, 1'b0, 1'b0}},
      '{ReqQuery, 8'h00, 1'b0, 24'hFF00FF, 1'b1, '{16'd2, 1'b0, 1'b0}},
      '{ReqData,  8'hFF, 1'b0, 24'hABCDEF, 1'b1, '{16'd1, 1'b1, 1'b0}},
      '{ReqData,  8'h00, 1'b0, 24'h000000, 1'b0, '0},
      '{ReqQuery, 8'h00, 1'b0, 24'hFFFFFF, 1'b0, '0},
      '{ReqData,  8'h00, 1'b0, 24'h000000, 1'b0, '0}
    };

    // Hold reset, then release it once. The block clears its
    // table afterwards with in_ready low; the handshake wait covers that.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      txn.req_type = dir_rows[r].req;
      txn.data_byte = dir_rows[r].data;
      txn.stream_start = dir_rows[r].start;
      txn.query_index = dir_rows[r].qidx;
      send_txn(txn, dir_rows[r].fixed, dir_rows[r].want);
    end

    // Saturation: one repeated byte hammers a single counter, through every
    // count bit, up to its maximum and past it.
    for (int unsigned k = 0; k < SatRunBytes; k++) begin
      txn.req_type = ReqData;
      txn.data_byte = SatByte;
      txn.stream_start = (k == 0);
      txn.query_index = index_t'($urandom);
      send_txn(txn, 1'b0, '0);
    end
    txn.req_type = ReqQuery;
    txn.data_byte = 8'($urandom);
    txn.stream_start = 1'($urandom);
    txn.query_index = {SatByte, SatByte, SatByte};
    send_txn(txn, 1'b0, '0);

    // Random part: mostly streams over small alphabets so that trigrams repeat
    // and counters climb, with queries mixed in; the rest is noise.
    foreach (pool[k]) pool[k] = 8'($urandom);
    n_rand = 0;
    while (n_rand < RandomItems) begin
      if ($urandom_range(0, 4) == 0) begin
        txn = in_t'({$urandom, $urandom});
        if (txn.req_type == ReqQuery && $urandom_range(0, 1) == 0)
          txn.query_index = pick_query();
        send_txn(txn, 1'b0, '0);
        n_rand++;
      end else begin
        foreach (sym[k]) sym[k] = ($urandom_range(0, 1) == 0) ? pool[k] : 8'($urandom);
        seg_len = $urandom_range(3, 30);
        for (int unsigned j = 0; j < seg_len; j++) begin
          txn.req_type = ReqData;
          txn.data_byte = sym[$urandom_range(0, 3)];
          // Open with a stream start; now and then break the stream midway.
          txn.stream_start = (j == 0) || ($urandom_range(0, 19) == 0);
          txn.query_index = index_t'($urandom);
          send_txn(txn, 1'b0, '0);
          n_rand++;
          if ($urandom_range(0, 5) == 0) begin
            txn.req_type = ReqQuery;
            txn.data_byte = 8'($urandom);
            txn.stream_start = 1'($urandom);
            txn.query_index = pick_query();
            send_txn(txn, 1'b0, '0);
            n_rand++;
          end
        end
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then idle for TailCycles to catch strays.
    drain = 0;
    while (pending_counts.size() != 0 && drain < DrainLimit) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (pending_counts.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_counts.size());
      errors++;
    end

    $display("Ran %0d data bytes and %0d queries; %0d trigrams counted.",
             n_data, n_query, n_formed);
    $display("Saturated counter seen in %0d results; %0d check failures.", n_sat, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: allow for the table clear after reset plus every transaction
  // at its slowest, several times over.
  initial begin : watchdog
    #720000000;
    $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
sv/btg_pkg.sv
sv/btg_ram.sv
sv/btg_hist.sv
sv/btg_rmw.sv
sv/byte_trigram_histogram_core.sv
dv/byte_trigram_histogram_core_tb.sv
